// ===== rtl/core/drdc_pkg.sv =====
// shared types, constants and segment decoder for the dual radix display counter
package drdc_pkg;

   localparam int CNT_W      = 16;
   localparam int UNIT_W     = 13;
   localparam int RATE_W     = 4;
   localparam int SEG_W      = 7;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 4;
   localparam int BCD_DIGITS = 5;
   localparam int BYTE_W     = 8;

   localparam logic [CNT_W-1:0]  DEC_LIMIT   = 16'd9999;
   localparam logic [CNT_W-1:0]  HEX_LIMIT   = 16'hFFFF;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 16'hF03C;
   localparam logic [UNIT_W-1:0] UNIT_RESET  = 13'd1000;
   localparam logic [RATE_W-1:0] RATE_RESET  = 4'd1;

   localparam logic [BYTE_W-1:0] CHAR_H = 8'h68;
   localparam logic [BYTE_W-1:0] CHAR_D = 8'h64;
   localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;

   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [BCD_DIGITS-1:0] bcd_type;
   typedef logic [SEG_W-1:0] seg_type;

   // decimal shadow of the reset count 0xF03C
   localparam bcd_type BCD_RESET = 20'h61500;

   // one result beat before segment decoding
   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      logic                             hex_mode;
      logic                             counted;
      digit_type [NUM_DIGITS-1:0]       digits;
   } disp_type;

   // segment a in bit 0 through segment g in bit 6
   function automatic seg_type seg_of(input digit_type d);
      seg_type s;
      unique case (d)
         4'h0: s = 7'h3F;
         4'h1: s = 7'h06;
         4'h2: s = 7'h5B;
         4'h3: s = 7'h4F;
         4'h4: s = 7'h66;
         4'h5: s = 7'h6D;
         4'h6: s = 7'h7D;
         4'h7: s = 7'h07;
         4'h8: s = 7'h7F;
         4'h9: s = 7'h67;
         4'hA: s = 7'h77;
         4'hB: s = 7'h7C;
         4'hC: s = 7'h58;
         4'hD: s = 7'h5E;
         4'hE: s = 7'h79;
         4'hF: s = 7'h71;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/drdc_if.sv =====
// channel interfaces: request, response and register write
interface drdc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [drdc_pkg::BYTE_W-1:0]   rx_byte;

   modport source(output valid, req_type, rx_byte, input ready);
   modport sink(input valid, req_type, rx_byte, output ready);
endinterface

interface drdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [drdc_pkg::CNT_W-1:0]    count_out;
   logic                          hex_mode;
   logic                          counted;
   logic [drdc_pkg::SEG_W-1:0]    seg_ones;
   logic [drdc_pkg::SEG_W-1:0]    seg_second;
   logic [drdc_pkg::SEG_W-1:0]    seg_third;
   logic [drdc_pkg::SEG_W-1:0]    seg_top;

   modport source(output valid, count_out, hex_mode, counted, seg_ones, seg_second,
                  seg_third, seg_top, input ready);
   modport sink(input valid, count_out, hex_mode, counted, seg_ones, seg_second,
                seg_third, seg_top, output ready);
endinterface

interface drdc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [drdc_pkg::UNIT_W-1:0]   interval_unit;

   modport source(output valid, interval_unit, input ready);
   modport sink(input valid, interval_unit, output ready);
endinterface

// ===== rtl/core/dual_radix_display_counter.sv =====
// top level of the dual radix display counter
//
//   channel   direction  beat carries
//   req_if    in         req_type, rx_byte
//   rsp_if    out        count_out, hex_mode, counted, four segment patterns
//   csr_if    in         interval_unit
//
// one beat per cycle sustained while rsp_if.ready stays high; a request beat
// that is taken passes through the input register, then the state update into
// the result register, before its result beat is valid
// reset is synchronous: count 0xF03C, hex mode, rate 1, phase 0, unit 1000
// a stalled result holds in the result register; one more request waits in
// the input register, after which req_if.ready drops
module dual_radix_display_counter (
   input  logic       clock,
   input  logic       reset,
   drdc_req_if.sink   req_if,
   drdc_rsp_if.source rsp_if,
   drdc_csr_if.sink   csr_if
);
   import drdc_pkg::*;

   // interval register, to be written only while idle; the user is bound to this, the block does not enforce it
   logic [UNIT_W-1:0] unit_ff, unit_in;

   // input register stage
   logic              s1_valid_ff, s1_valid_in;
   req_kind_type      s1_kind_ff, s1_kind_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;

   // result register stage
   logic              rsp_valid_ff, rsp_valid_in;
   disp_type          rsp_ff, rsp_in;

   logic              take;
   logic              out_free;
   logic              advance;
   disp_type          disp_next;
   seg_type [NUM_DIGITS-1:0] segs;

   // result register can load when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign advance  = s1_valid_ff && out_free;

   // input stage is free when empty or moving on this cycle
   assign req_if.ready = !reset && (!s1_valid_ff || out_free);
   assign take         = req_if.valid && req_if.ready;

   assign csr_if.ready = 1'b1;
   assign unit_in      = csr_if.valid ? csr_if.interval_unit : unit_ff;

   assign s1_valid_in = take || (s1_valid_ff && !advance);
   assign s1_kind_in  = take ? req_kind_type'(req_if.req_type) : s1_kind_ff;
   assign s1_byte_in  = take ? req_if.rx_byte : s1_byte_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_in       = advance ? disp_next : rsp_ff;

   drdc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_kind   (s1_kind_ff),
      .in_byte   (s1_byte_ff),
      .unit      (unit_ff),
      .disp_next (disp_next)
   );

   // decode from the registered digits, so the segment tables sit after the register
   drdc_seg u_seg (
      .digits (rsp_ff.digits),
      .segs   (segs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff      <= UNIT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_ff      <= unit_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_byte_ff <= s1_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.count_out  = rsp_ff.count;
   assign rsp_if.hex_mode   = rsp_ff.hex_mode;
   assign rsp_if.counted    = rsp_ff.counted;
   assign rsp_if.seg_ones   = segs[0];
   assign rsp_if.seg_second = segs[1];
   assign rsp_if.seg_third  = segs[2];
   assign rsp_if.seg_top    = segs[3];

endmodule

// ===== rtl/core/drdc_core.sv =====
// counter state and next-state logic for one item
module drdc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  drdc_pkg::req_kind_type      in_kind,
   input  logic [drdc_pkg::BYTE_W-1:0] in_byte,
   input  logic [drdc_pkg::UNIT_W-1:0] unit,
   output drdc_pkg::disp_type          disp_next
);
   import drdc_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   bcd_type           bcd_ff, bcd_in;
   logic              mode_hex_ff, mode_hex_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [CNT_W-1:0]  phase_ff, phase_in;

   logic [RATE_W:0]   rate_plus;
   logic [17:0]       product;
   logic [CNT_W-1:0]  target;
   logic [CNT_W:0]    phase_inc;
   logic              hit;
   logic              wrap;
   logic              counted;
   logic [BYTE_W-1:0] digit_off;
   bcd_type           bcd_plus;

   // ripple decimal increment over the shadow digits
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (carry && bcd_ff[i] == 4'd9) begin
            bcd_plus[i] = 4'd0;
         end else begin
            bcd_plus[i] = bcd_ff[i] + {3'b000, carry};
            carry       = 1'b0;
         end
      end
   end

   assign rate_plus = {1'b0, rate_ff} + 5'd1;
   assign product   = 18'(rate_plus) * 18'(unit);
   assign target    = (product > 18'(HEX_LIMIT)) ? HEX_LIMIT : product[CNT_W-1:0];
   assign phase_inc = {1'b0, phase_ff} + 17'd1;
   assign hit       = phase_inc >= {1'b0, target};
   assign wrap      = mode_hex_ff ? (count_ff == HEX_LIMIT) : (count_ff >= DEC_LIMIT);
   assign digit_off = in_byte - CHAR_0 + 8'd1;

   always_comb begin
      count_in    = count_ff;
      bcd_in      = bcd_ff;
      mode_hex_in = mode_hex_ff;
      rate_in     = rate_ff;
      phase_in    = phase_ff;
      counted     = 1'b0;
      if (in_kind == REQ_BYTE) begin
         priority if (in_byte >= CHAR_0 && in_byte <= CHAR_9) begin
            rate_in = digit_off[RATE_W-1:0];
         end else if (in_byte == CHAR_H) begin
            mode_hex_in = 1'b1;
         end else if (in_byte == CHAR_D) begin
            mode_hex_in = 1'b0;
            if (count_ff > DEC_LIMIT) begin
               count_in = '0;
               bcd_in   = '0;
            end
         end else begin
            rate_in = rate_ff;
         end
      end else if (hit) begin
         phase_in = '0;
         counted  = 1'b1;
         if (wrap) begin
            count_in = '0;
            bcd_in   = '0;
         end else begin
            count_in = count_ff + 16'd1;
            bcd_in   = bcd_plus;
         end
      end else begin
         phase_in = phase_inc[CNT_W-1:0];
      end
   end

   always_comb begin
      disp_next.count    = count_in;
      disp_next.hex_mode = mode_hex_in;
      disp_next.counted  = counted;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         disp_next.digits[i] = mode_hex_in ? count_in[i*DIGIT_W +: DIGIT_W] : bcd_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= COUNT_RESET;
         bcd_ff      <= BCD_RESET;
         mode_hex_ff <= 1'b1;
         rate_ff     <= RATE_RESET;
         phase_ff    <= '0;
      end else if (advance) begin
         count_ff    <= count_in;
         bcd_ff      <= bcd_in;
         mode_hex_ff <= mode_hex_in;
         rate_ff     <= rate_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

// ===== rtl/core/drdc_seg.sv =====
// seven-segment decode of the four display digits
module drdc_seg (
   input  drdc_pkg::digit_type [drdc_pkg::NUM_DIGITS-1:0] digits,
   output drdc_pkg::seg_type   [drdc_pkg::NUM_DIGITS-1:0] segs
);
   import drdc_pkg::*;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         segs[i] = seg_of(digits[i]);
      end
   end

endmodule

// ===== rtl/core/drdc_checker.sv =====
// port-level checks on the dual radix display counter and their binding
module drdc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [drdc_pkg::CNT_W-1:0]  count_out,
   input logic                        hex_mode
);
   import drdc_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result only rises after a request beat has passed through the input register
   a_rise_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a request beat");

   // decimal mode never shows a count above 9999
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !hex_mode |-> count_out <= DEC_LIMIT)
      else $error("decimal count out of range");

   // a stalled result holds its count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(count_out))
      else $error("stalled result changed");

endmodule

bind dual_radix_display_counter drdc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .count_out (rsp_if.count_out),
   .hex_mode  (rsp_if.hex_mode)
);

// ===== tb/dual_radix_display_counter_test.sv =====
// self-checking testbench for the dual radix display counter
`timescale 1ns / 100ps

module dual_radix_display_counter_test;
   import drdc_pkg::*;

   // clock of 12 ns, reset held at the start of the run
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   // no beat on any channel for this long means the block is stuck
   localparam int STUCK_LIMIT   = 2000;
   // receiver hold-off that backs the block up into its input
   localparam int HOLD_CYCLES   = 300;
   // ticks offered while the receiver holds off
   localparam int HOLD_ITEMS    = 40;
   // quiet time after the last result
   localparam int TAIL_CYCLES   = 10;
   localparam int PHASE_TOP     = 65535;
   localparam int ROWS          = 23;
   localparam int PHASE_ITEMS   = 200;
   localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

   // patterns for digits f down to 0, segment a in the low bit of each
   localparam logic [16*SEG_W-1:0] SEG_BITS = {
      7'h71, 7'h79, 7'h5E, 7'h58, 7'h7C, 7'h77, 7'h67, 7'h7F,
      7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };
   // four digits, most significant first: f 0 3 c and all zeros
   localparam logic [4*SEG_W-1:0] SEGS_F03C = {7'h71, 7'h3F, 7'h4F, 7'h58};
   localparam logic [4*SEG_W-1:0] SEGS_ZERO = {4{7'h3F}};

   // what the display shows after one beat
   typedef struct packed {
      logic [CNT_W-1:0]     count;
      logic                 hexm;
      logic                 stepped;
      logic [4*SEG_W-1:0]   segs;
   } display_type;

   // one row of the directed script, pinned rows carry a hand-written result
   typedef struct packed {
      req_kind_type         kind;
      logic [BYTE_W-1:0]    ch;
      logic                 pinned;
      display_type          want;
   } script_row_type;

   localparam display_type SHOW_RESET    = '{COUNT_RESET, 1'b1, 1'b0, SEGS_F03C};
   localparam display_type SHOW_ZERO_DEC = '{16'd0, 1'b0, 1'b0, SEGS_ZERO};
   localparam display_type SHOW_ZERO_HEX = '{16'd0, 1'b1, 1'b0, SEGS_ZERO};
   localparam display_type FROM_MODEL    = '0;

   logic clock;
   logic reset;

   drdc_req_if req_bus();
   drdc_rsp_if rsp_bus();
   drdc_csr_if csr_bus();

   dual_radix_display_counter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // predictor state, starting at the reset values
   logic [CNT_W-1:0]  count_now = COUNT_RESET;
   logic              hex_now   = 1'b1;
   logic [RATE_W-1:0] rate_now  = RATE_RESET;
   logic [CNT_W-1:0]  phase_now = '0;
   logic [UNIT_W-1:0] unit_now  = UNIT_RESET;

   display_type display_q[$];       // results still owed by the block
   display_type pinned_q[$];        // hand-written result per offered beat, or FROM_MODEL
   bit       pinned_on_q[$];
   int       errors  = 0;
   bit       calm    = 1'b0;        // no idling on either side
   bit       squeeze = 1'b0;        // ask the receiver for one long hold-off

   // directed part: extremes of the byte, every kind of byte, both radices
   script_row_type script [0:ROWS-1] = '{
      '{REQ_TICK, 8'h00,      1'b1, SHOW_RESET},      // first tick, far from the target
      '{REQ_BYTE, 8'h00,      1'b1, SHOW_RESET},      // lowest byte, ignored
      '{REQ_BYTE, 8'hFF,      1'b1, SHOW_RESET},      // highest byte, ignored
      '{REQ_BYTE, 8'h2F,      1'b1, SHOW_RESET},      // just below '0'
      '{REQ_BYTE, 8'h3A,      1'b1, SHOW_RESET},      // just above '9'
      '{REQ_BYTE, 8'h48,      1'b1, SHOW_RESET},      // upper-case h, ignored
      '{REQ_BYTE, 8'h44,      1'b1, SHOW_RESET},      // upper-case d, ignored
      '{REQ_BYTE, CHAR_H,     1'b1, SHOW_RESET},      // hex while already hex
      '{REQ_BYTE, CHAR_0,     1'b1, SHOW_RESET},      // fastest digit gives rate 1
      '{REQ_BYTE, CHAR_9,     1'b1, SHOW_RESET},      // rate 10
      '{REQ_TICK, 8'hA5,      1'b1, SHOW_RESET},      // payload byte of a tick is don't-care
      '{REQ_BYTE, CHAR_D,     1'b1, SHOW_ZERO_DEC},   // decimal clears a count above 9999
      '{REQ_BYTE, CHAR_D,     1'b1, SHOW_ZERO_DEC},   // decimal again
      '{REQ_TICK, 8'h00,      1'b1, SHOW_ZERO_DEC},
      '{REQ_BYTE, 8'h63,      1'b1, SHOW_ZERO_DEC},   // neighbours of d and h
      '{REQ_BYTE, 8'h65,      1'b1, SHOW_ZERO_DEC},
      '{REQ_BYTE, 8'h67,      1'b1, SHOW_ZERO_DEC},
      '{REQ_BYTE, 8'h69,      1'b1, SHOW_ZERO_DEC},
      '{REQ_BYTE, CHAR_H,     1'b1, SHOW_ZERO_HEX},
      '{REQ_BYTE, CHAR_0 + 8'd5, 1'b0, FROM_MODEL},
      '{REQ_TICK, 8'hFF,      1'b0, FROM_MODEL},
      '{REQ_BYTE, 8'h80,      1'b0, FROM_MODEL},
      '{REQ_BYTE, CHAR_D,     1'b0, FROM_MODEL}
   };

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // advance the display state by one accepted beat and give what it shows
   function automatic display_type apply_beat(req_kind_type kind, logic [BYTE_W-1:0] ch);
      display_type d;
      int       target;
      int       nxt;
      int       base;
      int       v;
      d = '0;
      if (kind == REQ_BYTE) begin
         if (ch >= CHAR_0 && ch <= CHAR_9) begin
            rate_now = RATE_W'(ch - CHAR_0 + 8'd1);
         end else if (ch == CHAR_H) begin
            hex_now = 1'b1;
         end else if (ch == CHAR_D) begin
            hex_now = 1'b0;
            if (count_now > DEC_LIMIT) count_now = '0;
         end
      end else begin
         // interval target saturates at the largest phase
         target = (int'(rate_now) + 1) * int'(unit_now);
         if (target > PHASE_TOP) target = PHASE_TOP;
         nxt = int'(phase_now) + 1;
         if (nxt >= target) begin
            phase_now = '0;
            d.stepped = 1'b1;
            if (!hex_now && count_now >= DEC_LIMIT) count_now = '0;
            else if (hex_now && count_now == HEX_LIMIT) count_now = '0;
            else count_now = count_now + 16'd1;
         end else begin
            phase_now = CNT_W'(nxt);
         end
      end
      base = hex_now ? 16 : 10;
      v = int'(count_now);
      for (int pos = 0; pos < NUM_DIGITS; pos++) begin
         d.segs[pos*SEG_W +: SEG_W] = SEG_BITS[(v % base)*SEG_W +: SEG_W];
         v = v / base;
      end
      d.count = count_now;
      d.hexm  = hex_now;
      return d;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      errors++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // offer one request beat, then maybe idle
   task automatic offer(req_kind_type kind, logic [BYTE_W-1:0] ch, bit pin, display_type want);
      int gap;
      pinned_q.push_back(want);
      pinned_on_q.push_back(pin);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.rx_byte  <= ch;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pause_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait until every owed result is back
   task automatic settle();
      req_bus.valid <= 1'b0;
      // let the scoreboard log a beat taken at this very edge
      @(posedge clock);
      while (display_q.size() != 0) @(posedge clock);
   endtask

   // the register is only touched once the block has gone idle
   task automatic write_unit(input logic [UNIT_W-1:0] unit);
      settle();
      csr_bus.valid         <= 1'b1;
      csr_bus.interval_unit <= unit;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // back-to-back ticks with no gaps from the sender
   task automatic tick_run(input int n);
      calm = 1'b1;
      repeat (n) offer(REQ_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, FROM_MODEL);
      calm = 1'b0;
   endtask

   // random beats: mostly ticks, then meaningful bytes, then noise
   task automatic random_phase(input logic [UNIT_W-1:0] unit, input int items);
      int                useful;
      int                r;
      logic [BYTE_W-1:0] ch;
      useful = 0;
      write_unit(unit);
      while (useful < items) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            offer(REQ_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, FROM_MODEL);
            useful++;
         end else begin
            if (r < 80) ch = CHAR_0 + BYTE_W'($urandom_range(0, 9));
            else if (r < 86) ch = CHAR_H;
            else if (r < 90) ch = CHAR_D;
            else ch = BYTE_W'($urandom_range(0, 255));
            offer(REQ_BYTE, ch, 1'b0, FROM_MODEL);
            // noise bytes that the block ignores are not counted
            if ((ch >= CHAR_0 && ch <= CHAR_9) || ch == CHAR_H || ch == CHAR_D) useful++;
         end
      end
   endtask

   // scoreboard: predict on every request beat, check every result beat
   always @(posedge clock) begin : scoreboard
      display_type want;
      display_type got;
      display_type pin_val;
      bit       pin_on;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) unit_now = csr_bus.interval_unit;
         if (req_bus.valid && req_bus.ready) begin
            want    = apply_beat(req_kind_type'(req_bus.req_type), req_bus.rx_byte);
            pin_val = pinned_q.pop_front();
            pin_on  = pinned_on_q.pop_front();
            // hand-written rows stand on their own
            if (pin_on) want = pin_val;
            display_q.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.count   = rsp_bus.count_out;
            got.hexm    = rsp_bus.hex_mode;
            got.stepped = rsp_bus.counted;
            got.segs    = {rsp_bus.seg_top, rsp_bus.seg_third, rsp_bus.seg_second,
                           rsp_bus.seg_ones};
            if (display_q.size() == 0) begin
               report_mismatch("unexpected result beat, count_out", int'(got.count), 0);
            end else begin
               want = display_q.pop_front();
               if (got.count !== want.count)
                  report_mismatch("count_out", int'(got.count), int'(want.count));
               if (got.hexm !== want.hexm)
                  report_mismatch("hex_mode", int'(got.hexm), int'(want.hexm));
               if (got.stepped !== want.stepped)
                  report_mismatch("counted", int'(got.stepped), int'(want.stepped));
               if (got.segs[0*SEG_W +: SEG_W] !== want.segs[0*SEG_W +: SEG_W])
                  report_mismatch("seg_ones", int'(got.segs[0*SEG_W +: SEG_W]),
                                  int'(want.segs[0*SEG_W +: SEG_W]));
               if (got.segs[1*SEG_W +: SEG_W] !== want.segs[1*SEG_W +: SEG_W])
                  report_mismatch("seg_second", int'(got.segs[1*SEG_W +: SEG_W]),
                                  int'(want.segs[1*SEG_W +: SEG_W]));
               if (got.segs[2*SEG_W +: SEG_W] !== want.segs[2*SEG_W +: SEG_W])
                  report_mismatch("seg_third", int'(got.segs[2*SEG_W +: SEG_W]),
                                  int'(want.segs[2*SEG_W +: SEG_W]));
               if (got.segs[3*SEG_W +: SEG_W] !== want.segs[3*SEG_W +: SEG_W])
                  report_mismatch("seg_top", int'(got.segs[3*SEG_W +: SEG_W]),
                                  int'(want.segs[3*SEG_W +: SEG_W]));
            end
         end
      end
   end

   // result side: random stalls, and one long hold-off on request
   initial begin : receiver
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze) begin
            squeeze = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pause_len();
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STUCK_LIMIT) begin
            $display("[dual_radix_display_counter] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_BYTE;
      req_bus.rx_byte       <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.interval_unit <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script at the reset interval
      for (int k = 0; k < ROWS; k++)
         offer(script[k].kind, script[k].ch, script[k].pinned, script[k].want);

      // receiver holds off while ticks keep coming, so the block backs up
      write_unit(13'd1);
      squeeze = 1'b1;
      tick_run(HOLD_ITEMS);

      // random phases over a spread of intervals
      random_phase(13'd1, PHASE_ITEMS);
      random_phase('0, PHASE_ITEMS);
      random_phase(UNIT_MAX, PHASE_ITEMS);
      random_phase(13'd2, PHASE_ITEMS);
      random_phase(13'd3, PHASE_ITEMS);
      random_phase(UNIT_W'($urandom_range(4, 40)), PHASE_ITEMS);
      random_phase(13'd5000, PHASE_ITEMS);
      random_phase(13'd1, PHASE_ITEMS);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[dual_radix_display_counter] OK");
      end else begin
         $display("[dual_radix_display_counter] ERROR");
      end
      $finish;
   end

endmodule
